// File: design/bls_pkg.sv
package bls_pkg;

   // Count width is fixed by the entry_count field and the 7-bit limit register.
   localparam int CNT_W = 7;
   localparam int CNT_MAX = 127;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [31:0] KEY_MASK_RESET = 32'hFFFF_FFFF;

   // Register select (paddr bit 2)
   localparam logic REG_DEPTH_LIMIT = 1'b0;
   localparam logic REG_KEY_MASK    = 1'b1;

   typedef enum logic [2:0] {
      OP_PUSH     = 3'd0,
      OP_POP      = 3'd1,
      OP_PEEK     = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_CONTAINS = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

endpackage

// File: design/bls_ram.sv
module bls_ram import bls_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int DATA_WIDTH = 32,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bls_match.sv
module bls_match import bls_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic [DATA_WIDTH-1:0] entry,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic [DATA_WIDTH-1:0] mask,
   output logic                  hit
);

   // shared compare used by every step of the contains walk
   assign hit = ((entry ^ key) & mask) == '0;

endmodule

// File: design/bounded_lifo_stack_core.sv
// Bounded LIFO stack with masked search.
//
// Command channel: an item (req_opcode, req_push_value, req_search_key) is
// taken on a rising edge with start high and busy low. Each item yields one
// result, shown for a single cycle with rsp_valid high; the receiver cannot
// stall, so results must be taken as they appear.
// Sequencing from the transfer to rsp_valid:
//   push, clear, unknown opcodes, contains on an empty stack, and any op that
//     fails: result next cycle, busy stays low, so these may issue every cycle.
//   pop / peek: RAM read launched at the transfer; ST_READ registers the result.
//   contains: walks entries from the bottom, one RAM read and one masked
//     compare per cycle through a single comparator; stops at the first hit.
//     An item compares at most count entries.
// busy is high while a pop/peek read or a contains walk is in progress.
// CSR port: APB-style, depth_limit at 0x0, key_mask at 0x4; write only idle.
// Reset: count clears, depth_limit = 64, key_mask = all ones; stack storage
// is not cleared, entries above count are never read.

module bounded_lifo_stack_core import bls_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_push_value,
   input  logic [31:0] req_search_key,
   // result channel
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [1:0]  rsp_error_code,
   output logic [31:0] rsp_read_data,
   output logic        rsp_found,
   output logic [6:0]  rsp_entry_count,
   output logic        rsp_is_empty,
   output logic        rsp_is_full,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ADDR_W = $clog2(DEPTH);
   // effective limit never exceeds what the 7-bit count can hold
   localparam int LIM_CAP = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

   // config registers
   logic [CNT_W-1:0]      depth_limit_ff;
   logic [31:0]           key_mask_ff;

   // control state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;       // next entry to read in a walk
   op_type                op_ff, op_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   err_type               rsp_err_ff, rsp_err_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_empty_ff, rsp_full_ff;

   // RAM and comparator hookup
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic                  hit;

   logic [CNT_W-1:0]      limit;
   logic                  csr_write;

   // ------------------------------------------------------------------
   // CSR port
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= LIMIT_RESET;
         key_mask_ff    <= KEY_MASK_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_DEPTH_LIMIT) begin
            depth_limit_ff <= pwdata[CNT_W-1:0];
         end else begin
            key_mask_ff <= pwdata;
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_KEY_MASK) begin
         prdata = key_mask_ff;
      end else begin
         prdata = 32'(depth_limit_ff);
      end
   end

   assign limit = (depth_limit_ff > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : depth_limit_ff;

   // ------------------------------------------------------------------
   // storage and shared comparator
   // ------------------------------------------------------------------
   bls_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bls_match #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_match (
      .entry (ram_rdata),
      .key   (key_ff),
      .mask  (DATA_WIDTH'(key_mask_ff)),
      .hit   (hit)
   );

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      // status reflects the count after this cycle's update
      rsp_count_ff <= count_in;
      rsp_empty_ff <= (count_in == '0);
      rsp_full_ff  <= (count_in >= limit);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_W'(count_ff);
      ram_wdata    = DATA_WIDTH'(req_push_value);
      ram_raddr    = ADDR_W'(count_ff - CNT_W'(1));
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_err_in   = ERR_NONE;
      rsp_data_in  = '0;
      rsp_found_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_opcode);
               key_in = DATA_WIDTH'(req_search_key);
               case (op_type'(req_opcode))
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= limit) begin
                        rsp_err_in = ERR_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        rsp_ok_in = 1'b1;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = ERR_EMPTY;
                     end else begin
                        // top entry read launched here
                        state_in = ST_READ;
                     end
                  end
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                  end
                  OP_CONTAINS: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                     end else begin
                        ram_raddr = '0;
                        ptr_in    = CNT_W'(1);
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                     // unknown opcode: no change, ok low, no error
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_data_in  = 32'(ram_rdata);
            if (op_ff == OP_POP) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // ram_rdata holds entry ptr_ff-1
            if (hit || ptr_ff == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_found_in = hit;
               state_in     = ST_IDLE;
            end else begin
               ram_raddr = ADDR_W'(ptr_ff);
               ptr_in    = ptr_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule
